// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the token replacer RTL.
// Assumes a clock named clock and an active-high reset named reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define FTR_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define FTR_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define FTR_ASSERT(lbl, prop, msg)
`define FTR_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// ===== rtl/ftr_pkg.sv =====
// Types, constants and token lookup for the token replacer.
// No dependencies.
`default_nettype none

package ftr_pkg;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_PREFIX,
      PH_TAB,
      PH_NL
   } phase_type;

   typedef logic [3:0] cnt_type;
   typedef logic [4:0] idx_type;

   localparam cnt_type PREFIX_LEN = 4'd4;
   localparam cnt_type TAB_LEN    = 4'd7;
   localparam cnt_type NL_LEN     = 4'd11;

   localparam logic [7:0] CH_O   = 8'h4F;
   localparam logic [7:0] CH_T   = 8'h54;
   localparam logic [7:0] CH_N   = 8'h4E;
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_NL  = 8'h0A;

   // One queued command: replay of a held prefix, an optional literal word,
   // then a second replay (held prefix flushed on the last word).
   typedef struct packed {
      cnt_type    rep1_len;
      logic       rep1_nl;
      logic       has_lit;
      logic [7:0] lit;
      cnt_type    rep2_len;
      logic       rep2_nl;
      logic       last;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   // k-th byte of the tab token (nl = 0) or the newline token (nl = 1).
   function automatic logic [7:0] tok_byte(input logic nl, input cnt_type k);
      logic [7:0] b;
      b = 8'h00;
      case (k)
         4'd0:    b = "O";
         4'd1:    b = "O";
         4'd2:    b = "P";
         4'd3:    b = "_";
         4'd4:    b = nl ? "N" : "T";
         4'd5:    b = nl ? "E" : "A";
         4'd6:    b = nl ? "W" : "B";
         4'd7:    b = nl ? "L" : 8'h00;
         4'd8:    b = nl ? "I" : 8'h00;
         4'd9:    b = nl ? "N" : 8'h00;
         4'd10:   b = nl ? "E" : 8'h00;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/fixed_token_replacer.sv =====
// Top level of the token replacer: matcher, command queue, output sequencer.
// Depends on ftr_pkg, ftr_front, ftr_cmd_fifo, ftr_back.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   req_in_byte, req_in_last
//   rsp      out        rsp_valid/rsp_stall   rsp_out_byte, rsp_run_last, rsp_stream_end
//
// Input takes one word per cycle while the command queue has room.
// Output gives one word per cycle while rsp_stall is low; a word causing n
// results holds the sequencer for all n (up to 11 on a mismatch after a long
// held prefix). Commands are registered in the queue, words in the output register.
// QUEUE_DEPTH commands are buffered; a full queue raises req_stall.
// Synchronous reset returns the matcher to idle and empties the queue.
`default_nettype none

module fixed_token_replacer #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_in_last,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_run_last,
   output logic            rsp_stream_end
);
   import ftr_pkg::*;

   cmd_type   cmd_push, cmd_head;
   qstat_type q_stat;
   logic      push, pop;

   ftr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_byte (req_in_byte),
      .req_in_last (req_in_last),
      .q_stat      (q_stat),
      .push        (push),
      .cmd         (cmd_push)
   );

   ftr_cmd_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .din   (cmd_push),
      .pop   (pop),
      .dout  (cmd_head),
      .stat  (q_stat)
   );

   ftr_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (cmd_head),
      .q_stat         (q_stat),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_run_last   (rsp_run_last),
      .rsp_stream_end (rsp_stream_end)
   );

endmodule

`default_nettype wire

// ===== rtl/ftr_front.sv =====
// Front end: token matcher that turns each input word into at most one command.
// Depends on ftr_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ftr_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire logic [7:0]      req_in_byte,
   input  wire logic            req_in_last,
   input  wire ftr_pkg::qstat_type q_stat,
   output logic                 push,
   output ftr_pkg::cmd_type     cmd
);
   import ftr_pkg::*;

   phase_type  phase_ff, phase_in, mid_phase;
   cnt_type    count_ff, count_in, mid_count;
   logic       miss, hit_lit, accept;
   logic [7:0] lit;

   assign req_stall = q_stat.full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      mid_phase = phase_ff;
      mid_count = count_ff;
      miss      = 1'b0;
      hit_lit   = 1'b0;
      lit       = req_in_byte;
      case (phase_ff)
         PH_IDLE: begin
            miss = 1'b1;
         end
         PH_PREFIX: begin
            if (count_ff < PREFIX_LEN) begin
               if (req_in_byte == tok_byte(1'b0, count_ff)) begin
                  mid_count = count_ff + 4'd1;
               end else begin
                  miss = 1'b1;
               end
            end else if (count_ff == PREFIX_LEN && req_in_byte == CH_T) begin
               mid_phase = PH_TAB;
               mid_count = count_ff + 4'd1;
            end else if (count_ff == PREFIX_LEN && req_in_byte == CH_N) begin
               mid_phase = PH_NL;
               mid_count = count_ff + 4'd1;
            end else begin
               miss = 1'b1;
            end
         end
         PH_TAB: begin
            if (count_ff < TAB_LEN && req_in_byte == tok_byte(1'b0, count_ff)) begin
               if (count_ff == TAB_LEN - 4'd1) begin
                  mid_phase = PH_IDLE;
                  mid_count = 4'd0;
                  hit_lit   = 1'b1;
                  lit       = CH_TAB;
               end else begin
                  mid_count = count_ff + 4'd1;
               end
            end else begin
               miss = 1'b1;
            end
         end
         PH_NL: begin
            if (count_ff < NL_LEN && req_in_byte == tok_byte(1'b1, count_ff)) begin
               if (count_ff == NL_LEN - 4'd1) begin
                  mid_phase = PH_IDLE;
                  mid_count = 4'd0;
                  hit_lit   = 1'b1;
                  lit       = CH_NL;
               end else begin
                  mid_count = count_ff + 4'd1;
               end
            end else begin
               miss = 1'b1;
            end
         end
         default: begin
            miss = 1'b1;
         end
      endcase
      // restart: only a leading O may open a new match
      if (miss) begin
         if (req_in_byte == CH_O) begin
            mid_phase = PH_PREFIX;
            mid_count = 4'd1;
         end else begin
            mid_phase = PH_IDLE;
            mid_count = 4'd0;
            hit_lit   = 1'b1;
            lit       = req_in_byte;
         end
      end
   end

   // next state
   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      if (accept) begin
         phase_in = req_in_last ? PH_IDLE : mid_phase;
         count_in = req_in_last ? 4'd0 : mid_count;
      end
   end

   // command out
   always_comb begin
      cmd.rep1_len = miss ? count_ff : 4'd0;
      cmd.rep1_nl  = (phase_ff == PH_NL);
      cmd.has_lit  = hit_lit;
      cmd.lit      = lit;
      cmd.rep2_len = req_in_last ? mid_count : 4'd0;
      cmd.rep2_nl  = (mid_phase == PH_NL);
      cmd.last     = req_in_last;
      push = accept && (cmd.rep1_len != 4'd0 || hit_lit || cmd.rep2_len != 4'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         count_ff <= 4'd0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
   end

   `FTR_ASSERT(a_idle_empty, (phase_ff == PH_IDLE) |-> (count_ff == 4'd0), "idle with held bytes")
   `FTR_ASSERT(a_last_flush, (accept && req_in_last) |=> (phase_ff == PH_IDLE), "no flush on last")

endmodule

`default_nettype wire

// ===== rtl/ftr_cmd_fifo.sv =====
// Command queue between matcher and output sequencer.
// Depends on ftr_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ftr_cmd_fifo #(
   parameter int DEPTH = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire ftr_pkg::cmd_type  din,
   input  wire logic              pop,
   output ftr_pkg::cmd_type       dout,
   output ftr_pkg::qstat_type     stat
);
   import ftr_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;

   assign stat.full  = (fill_ff == CNT_W'(DEPTH));
   assign stat.empty = (fill_ff == '0);
   assign dout       = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   `FTR_ASSERT(a_no_overflow, push |-> !stat.full, "push into full queue")
   `FTR_ASSERT(a_no_underflow, pop |-> !stat.empty, "pop from empty queue")

endmodule

`default_nettype wire

// ===== rtl/ftr_back.sv =====
// Back end: expands queued commands into output words, one per cycle while not stalled.
// Depends on ftr_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ftr_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire ftr_pkg::cmd_type  head,
   input  wire ftr_pkg::qstat_type q_stat,
   output logic                   pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_run_last,
   output logic                   rsp_stream_end
);
   import ftr_pkg::*;

   idx_type    idx_ff, idx_in, total, rel;
   logic       head_valid, out_free, fire, at_end;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       run_last_ff, stream_end_ff;

   assign head_valid = !q_stat.empty;
   assign out_free   = !valid_ff || !rsp_stall;
   assign fire       = head_valid && out_free;
   assign total      = {1'b0, head.rep1_len} + {4'b0, head.has_lit} + {1'b0, head.rep2_len};
   assign rel        = idx_ff - {1'b0, head.rep1_len} - {4'b0, head.has_lit};
   assign at_end     = (idx_ff == total - 5'd1);
   assign pop        = fire && at_end;

   always_comb begin
      if (idx_ff < {1'b0, head.rep1_len}) begin
         byte_in = tok_byte(head.rep1_nl, idx_ff[3:0]);
      end else if (head.has_lit && idx_ff == {1'b0, head.rep1_len}) begin
         byte_in = head.lit;
      end else begin
         byte_in = tok_byte(head.rep2_nl, rel[3:0]);
      end
   end

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff && rsp_stall;
      if (fire) begin
         valid_in = 1'b1;
         idx_in   = at_end ? 5'd0 : idx_ff + 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 5'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         byte_ff       <= byte_in;
         run_last_ff   <= at_end;
         stream_end_ff <= at_end && head.last;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_out_byte   = byte_ff;
   assign rsp_run_last   = run_last_ff;
   assign rsp_stream_end = stream_end_ff;

   `FTR_ASSERT(a_idx_range, head_valid |-> (idx_ff < total), "index past command")
   `FTR_ASSERT(a_idx_rest, !head_valid |-> (idx_ff == 5'd0), "index left over")
   `FTR_ASSERT_RST(a_rst_idle, reset |=> !valid_ff, "output valid after reset")

endmodule

`default_nettype wire
